// ----- design/yaz0_pkg.sv -----
// Shared types and constants for the Yaz0 decompressor.
package yaz0_pkg;

  localparam int unsigned WindowBytes    = 4096;
  localparam int unsigned BytesPerResult = 8;
  localparam int unsigned HeaderLen      = 16;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StTooSmall = 3'd1;
  localparam logic [2:0] StBadMagic = 3'd2;
  localparam logic [2:0] StCapShort = 3'd3;
  localparam logic [2:0] StBadRef   = 3'd4;

  localparam logic [7:0] MagicY  = 8'h59;
  localparam logic [7:0] MagicA  = 8'h61;
  localparam logic [7:0] MagicZ  = 8'h7a;
  localparam logic [7:0] Magic0  = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // consume the input word (header/token decode)
    logic copy_step; // move one byte of the active copy
    logic emit;      // push the packed result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic copy_busy; // copy bytes remain
    logic pack_full; // pack buffer holds a full word
    logic pack_any;  // pack buffer holds bytes
    logic fin;       // stream finished
    logic out_free;  // output register can take a word
  } stat_t;

endpackage

// ----- design/yaz0_if.sv -----
// Valid/ready channel interfaces for input and output words.
interface yaz0_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface yaz0_out_if #(parameter int unsigned BPR = yaz0_pkg::BytesPerResult);
  logic                 valid;
  logic                 ready;
  logic [8*BPR-1:0]     out_bytes;
  logic [3:0]           out_count;
  logic                 run_end;
  logic                 stream_end;
  logic [2:0]           status;
  modport source (output valid, output out_bytes, output out_count, output run_end,
                  output stream_end, output status, input ready);
  modport sink (input valid, input out_bytes, input out_count, input run_end,
                input stream_end, input status, output ready);
endinterface

// ----- design/yaz0_dp.sv -----
// Datapath: header/token decode, history memory, copy engine, packer, output reg.
module yaz0_dp #(
  parameter int unsigned BPR = yaz0_pkg::BytesPerResult
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cap_we,
  input  logic [31:0]           cap_wdata,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  yaz0_pkg::cmd_t        cmd,
  output yaz0_pkg::stat_t       stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [8*BPR-1:0]      out_bytes,
  output logic [3:0]            out_count,
  output logic                  run_end,
  output logic                  stream_end,
  output logic [2:0]            status
);
  localparam int unsigned AW = $clog2(yaz0_pkg::WindowBytes);
  localparam int unsigned CW = $clog2(BPR + 1);

  logic [7:0]  history [yaz0_pkg::WindowBytes];
  logic [31:0] out_capacity;
  logic [4:0]  header_index;
  logic [31:0] expanded_size;
  logic [31:0] produced_count;
  logic [7:0]  flag_byte;
  logic [3:0]  flag_bits_left;
  logic [1:0]  token_phase;
  logic [15:0] pending_code;
  logic [2:0]  error_code;
  logic        magic_bad;
  logic        finished;
  logic [8:0]  copy_left;
  logic [AW-1:0] copy_src;
  logic [7:0]  rd_data;
  logic        rd_pending;
  logic [8*BPR-1:0] pack_data;
  logic [CW-1:0]    pack_cnt;

  logic       fin_set;
  logic [2:0] fin_code;
  logic       tok_fin;
  logic       copy_fin;
  logic       copy_done;

  // Decode of the accepted byte
  logic [31:0] size_shift;
  logic        magic_ok;
  logic [31:0] room;
  logic        lit_put;

  always_comb begin
    unique case (header_index[1:0])
      2'd0: magic_ok = (in_byte == yaz0_pkg::MagicY);
      2'd1: magic_ok = (in_byte == yaz0_pkg::MagicA);
      2'd2: magic_ok = (in_byte == yaz0_pkg::MagicZ);
      default: magic_ok = (in_byte == yaz0_pkg::Magic0);
    endcase
    size_shift = {expanded_size[23:0], in_byte};
    room = (out_capacity > produced_count) ? out_capacity - produced_count : 32'd0;
    lit_put = (token_phase == 2'd0) && (flag_bits_left != 4'd0) && flag_byte[7] &&
              (produced_count < out_capacity);
  end

  logic [15:0] code_now;
  assign code_now = (token_phase == 2'd1) ? {pending_code[15:8], in_byte} : pending_code;

  logic [31:0] cdist;
  assign cdist = {20'd0, code_now[11:0]} + 32'd1;

  logic bad_now;
  assign bad_now = cdist > produced_count;

  logic [8:0] clen_now;
  always_comb begin
    clen_now = 9'd0;
    if (token_phase == 2'd1 && pending_code[15:12] != 4'd0) begin
      clen_now = {5'd0, pending_code[15:12]} + 9'd2;
    end else if (token_phase == 2'd2) begin
      clen_now = {1'b0, in_byte} + 9'd18;
    end
  end

  logic [8:0] clip_now;
  assign clip_now = (room < {23'd0, clen_now}) ? room[8:0] : clen_now;

  // Byte written this cycle (literal or copy)
  logic       wr_en;
  logic [7:0] wr_data;
  logic       copy_fire;
  assign copy_fire = cmd.copy_step && rd_pending && (pack_cnt != CW'(BPR));
  assign wr_en   = (cmd.take && !finished && header_index == 5'(yaz0_pkg::HeaderLen)
                    && lit_put) || copy_fire;
  assign wr_data = copy_fire ? rd_data : in_byte;

  // History write and registered read
  logic rd_issue;
  assign rd_issue = (copy_left != 9'd0) && (!rd_pending || copy_fire);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      history[produced_count[AW-1:0]] <= wr_data;
    end
    if (rd_issue) begin
      rd_data <= (copy_fire && copy_src == produced_count[AW-1:0]) ? wr_data
                 : history[copy_src];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity   <= 32'hffff_ffff;
      header_index   <= 5'd0;
      expanded_size  <= 32'd0;
      produced_count <= 32'd0;
      flag_byte      <= 8'd0;
      flag_bits_left <= 4'd0;
      token_phase    <= 2'd0;
      pending_code   <= 16'd0;
      error_code     <= yaz0_pkg::StOk;
      magic_bad      <= 1'b0;
      finished       <= 1'b0;
      copy_left      <= 9'd0;
      rd_pending     <= 1'b0;
      pack_cnt       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cap_we) begin
        out_capacity <= cap_wdata;
      end
      if (wr_en) begin
        produced_count <= produced_count + 32'd1;
      end
      if (rd_issue) begin
        copy_left <= copy_left - 9'd1;
        copy_src  <= copy_src + AW'(1);
      end
      rd_pending <= rd_issue || (rd_pending && !copy_fire);
      if (fin_set) begin
        finished   <= 1'b1;
        error_code <= fin_code;
      end else if (copy_done) begin
        finished   <= 1'b1;
        error_code <= yaz0_pkg::StOk;
      end
      // Decode the accepted word
      if (cmd.take && !finished) begin
        if (header_index != 5'(yaz0_pkg::HeaderLen)) begin
          header_index <= header_index + 5'd1;
          if (header_index < 5'd4 && !magic_ok) begin
            magic_bad <= 1'b1;
          end
          if (header_index >= 5'd4 && header_index < 5'd8) begin
            expanded_size <= size_shift;
          end
        end else if (token_phase == 2'd0) begin
          if (flag_bits_left == 4'd0) begin
            flag_byte      <= in_byte;
            flag_bits_left <= 4'd8;
          end else begin
            flag_byte      <= {flag_byte[6:0], 1'b0};
            flag_bits_left <= flag_bits_left - 4'd1;
            if (!flag_byte[7]) begin
              pending_code <= {in_byte, 8'd0};
              token_phase  <= 2'd1;
            end
          end
        end else if (token_phase == 2'd1) begin
          pending_code <= code_now;
          if (pending_code[15:12] != 4'd0) begin
            token_phase <= 2'd0;
          end else begin
            token_phase <= 2'd2;
          end
        end else begin
          token_phase <= 2'd0;
        end
        if (header_index == 5'(yaz0_pkg::HeaderLen) && clen_now != 9'd0 && !bad_now) begin
          copy_left <= clip_now;
          copy_src  <= produced_count[AW-1:0] - cdist[AW-1:0];
        end
      end
      // Pack buffer count
      if (cmd.emit) begin
        pack_cnt <= (wr_en) ? CW'(1) : '0;
      end else if (wr_en) begin
        pack_cnt <= pack_cnt + CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stream end conditions for the accepted word
  always_comb begin
    fin_set  = 1'b0;
    fin_code = yaz0_pkg::StOk;
    tok_fin  = 1'b0;
    if (cmd.take && !finished) begin
      if (header_index != 5'(yaz0_pkg::HeaderLen)) begin
        if (header_index == 5'd7) begin
          if (magic_bad || size_shift == 32'd0) begin
            fin_set = 1'b1;
            fin_code = yaz0_pkg::StBadMagic;
          end else if (out_capacity < size_shift) begin
            fin_set = 1'b1;
            fin_code = yaz0_pkg::StCapShort;
          end else if (in_last) begin
            fin_set = 1'b1;
          end
        end else if (in_last) begin
          fin_set = 1'b1;
          fin_code = (header_index < 5'd7) ? yaz0_pkg::StTooSmall : yaz0_pkg::StOk;
        end
      end else if (clen_now != 9'd0 && bad_now) begin
        fin_set = 1'b1;
        fin_code = yaz0_pkg::StBadRef;
      end else if (clen_now != 9'd0 && clip_now != 9'd0) begin
        tok_fin = in_last || ({23'd0, clip_now} >= room);
      end else begin
        fin_set = in_last || (produced_count + {31'd0, lit_put} >= out_capacity);
      end
    end
  end

  // Deferred end for a copy: raised when its last byte is written
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_fin <= 1'b0;
    end else if (tok_fin) begin
      copy_fin <= 1'b1;
    end else if (copy_fire && copy_left == 9'd0 && !rd_issue) begin
      copy_fin <= 1'b0;
    end
  end
  assign copy_done = copy_fin && copy_fire && copy_left == 9'd0;

  // Pack buffer lanes and output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bytes  <= pack_data;
      out_count  <= 4'(pack_cnt);
      run_end    <= !stat.copy_busy;
      stream_end <= !stat.copy_busy && stat.fin;
      status     <= error_code;
    end
    for (int i = 0; i < BPR; i++) begin
      if (rst) begin
        pack_data[8*i +: 8] <= 8'd0;
      end else if (cmd.emit) begin
        pack_data[8*i +: 8] <= (wr_en && i == 0) ? wr_data : 8'd0;
      end else if (wr_en && pack_cnt == CW'(i)) begin
        pack_data[8*i +: 8] <= wr_data;
      end
    end
  end

  assign stat.copy_busy = (copy_left != 9'd0) || rd_pending;
  assign stat.pack_full = (pack_cnt == CW'(BPR));
  assign stat.pack_any  = (pack_cnt != '0);
  assign stat.fin       = finished;
  assign stat.out_free  = !out_valid || out_ready;
endmodule

// ----- design/yaz0_ctrl.sv -----
// Controller: sequences word intake, copy steps and result emission.
module yaz0_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  yaz0_pkg::stat_t stat,
  output yaz0_pkg::cmd_t  cmd
);
  yaz0_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= yaz0_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      yaz0_pkg::ST_IDLE:  if (in_valid) state_next = yaz0_pkg::ST_COPY;
      yaz0_pkg::ST_COPY:  if (!stat.copy_busy || stat.pack_full) state_next = yaz0_pkg::ST_FLUSH;
      yaz0_pkg::ST_FLUSH: if (stat.out_free) state_next = stat.copy_busy ? yaz0_pkg::ST_COPY
                                                          : yaz0_pkg::ST_IDLE;
      default:            state_next = yaz0_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      yaz0_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      yaz0_pkg::ST_COPY: cmd.copy_step = 1'b1;
      yaz0_pkg::ST_FLUSH: begin
        cmd.copy_step = 1'b0;
        cmd.emit = stat.out_free && (stat.pack_any || (!stat.copy_busy && stat.fin));
      end
      default: cmd = '0;
    endcase
  end
endmodule

// ----- design/yaz0_lz_decompressor_core.sv -----
// Top level of the streaming Yaz0 decompressor.
// Usage:
//   in_ch  carries one compressed byte per word with in_last on the final byte.
//   out_ch carries up to BYTES_PER_RESULT decoded bytes per word, lowest lane
//   first, with out_count, run_end (last word for that input byte),
//   stream_end and status.
//   out_capacity_we/out_capacity_wdata write the destination size; write it
//   only while the block is idle.
// Timing: each header, flag or literal byte passes through the idle, copy and
// flush states before the next byte is taken. A back-reference moves one byte
// per cycle from the 4096-byte history through a registered read port, pausing
// in the flush state to hand over each full word of the pack buffer.
// Reset clears all control state and the capacity goes to all ones; the
// history needs no clearing since a reference before the output start is
// rejected. When out_ch stalls, the finished word holds in the output
// register and decoding pauses until it is taken.
module yaz0_lz_decompressor_core #(
  parameter int unsigned BYTES_PER_RESULT = yaz0_pkg::BytesPerResult
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             out_capacity_we,
  input  logic [31:0]      out_capacity_wdata,
  yaz0_in_if.sink          in_ch,
  yaz0_out_if.source       out_ch
);
  yaz0_pkg::cmd_t  cmd;
  yaz0_pkg::stat_t stat;

  yaz0_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  yaz0_dp #(.BPR(BYTES_PER_RESULT)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cap_we     (out_capacity_we),
    .cap_wdata  (out_capacity_wdata),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.in_last),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_bytes  (out_ch.out_bytes),
    .out_count  (out_ch.out_count),
    .run_end    (out_ch.run_end),
    .stream_end (out_ch.stream_end),
    .status     (out_ch.status)
  );
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the streaming Yaz0 decompressor core.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {
    TK_START,
    TK_SECOND,
    TK_LONG
  } tok_phase_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        run_end;
    logic        stream_end;
    logic [2:0]  status;
  } dec_word_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainWait = 60;

  logic        clk;
  logic        rst;
  logic        cap_we;
  logic [31:0] cap_wdata;

  yaz0_in_if     in_ch ();
  yaz0_out_if #(8) out_ch ();

  yaz0_lz_decompressor_core #(.BYTES_PER_RESULT(8)) DUT (
    .clk                (clk),
    .rst                (rst),
    .out_capacity_we    (cap_we),
    .out_capacity_wdata (cap_wdata),
    .in_ch              (in_ch),
    .out_ch             (out_ch)
  );

  // Decoder shadow state
  logic [7:0]  dec_hist [yaz0_pkg::WindowBytes];
  logic [31:0] dec_cap;
  int unsigned dec_hdr_idx;
  logic [31:0] dec_size;
  logic [31:0] dec_count;
  logic [7:0]  dec_flags;
  int unsigned dec_flags_left;
  tok_phase_t  dec_phase;
  logic [15:0] dec_code;
  logic [2:0]  dec_err;
  bit          dec_magic_bad;
  bit          dec_done;

  dec_word_t   expected_words[$];
  logic [7:0]  run_bytes[$];
  int          fails = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic void end_stream(logic [2:0] code);
    dec_done = 1'b1;
    dec_err  = code;
  endfunction

  function automatic void put_decoded(logic [7:0] v);
    dec_hist[dec_count[11:0]] = v;
    dec_count++;
    run_bytes.push_back(v);
  endfunction

  function automatic void run_backref(int unsigned len);
    logic [31:0] span;
    logic [31:0] room;
    logic [31:0] n;
    span = {20'd0, dec_code[11:0]} + 32'd1;
    if (span > dec_count) begin
      end_stream(yaz0_pkg::StBadRef);
      return;
    end
    room = (dec_cap > dec_count) ? dec_cap - dec_count : 32'd0;
    n = (len > room) ? room : len;
    for (int unsigned i = 0; i < n; i++) begin
      put_decoded(dec_hist[12'(dec_count - span)]);
    end
  endfunction

  // Pack this byte's output run into words
  function automatic void pack_run();
    dec_word_t w;
    int unsigned c;
    if (run_bytes.size() == 0) begin
      if (dec_done) begin
        w = '0;
        w.run_end = 1'b1;
        w.stream_end = 1'b1;
        w.status = dec_err;
        expected_words.push_back(w);
      end
      return;
    end
    while (run_bytes.size() > 0) begin
      w = '0;
      c = 0;
      while (c < 8 && run_bytes.size() > 0) begin
        w.bytes[8*c +: 8] = run_bytes.pop_front();
        c++;
      end
      w.cnt = c[3:0];
      w.run_end = (run_bytes.size() == 0);
      w.stream_end = w.run_end && dec_done;
      w.status = dec_err;
      expected_words.push_back(w);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, bit last);
    bit lit;
    logic [7:0] magic_ref;
    run_bytes.delete();
    if (dec_done) begin
      pack_run();
      return;
    end
    if (dec_hdr_idx < yaz0_pkg::HeaderLen) begin
      if (dec_hdr_idx < 4) begin
        case (dec_hdr_idx)
          0: magic_ref = yaz0_pkg::MagicY;
          1: magic_ref = yaz0_pkg::MagicA;
          2: magic_ref = yaz0_pkg::MagicZ;
          default: magic_ref = yaz0_pkg::Magic0;
        endcase
        if (b != magic_ref) dec_magic_bad = 1'b1;
      end else if (dec_hdr_idx < 8) begin
        dec_size = {dec_size[23:0], b};
      end
      if (dec_hdr_idx == 7) begin
        if (dec_magic_bad || dec_size == 0) end_stream(yaz0_pkg::StBadMagic);
        else if (dec_cap < dec_size) end_stream(yaz0_pkg::StCapShort);
      end else if (dec_hdr_idx < 7 && last) begin
        end_stream(yaz0_pkg::StTooSmall);
      end
      dec_hdr_idx++;
      if (!dec_done && last) end_stream(yaz0_pkg::StOk);
      pack_run();
      return;
    end
    case (dec_phase)
      TK_START: begin
        if (dec_flags_left == 0) begin
          dec_flags = b;
          dec_flags_left = 8;
        end else begin
          lit = dec_flags[7];
          dec_flags = dec_flags << 1;
          dec_flags_left--;
          if (lit) begin
            if (dec_count < dec_cap) put_decoded(b);
          end else begin
            dec_code = {b, 8'd0};
            dec_phase = TK_SECOND;
          end
        end
      end
      TK_SECOND: begin
        dec_code[7:0] = b;
        if (dec_code[15:12] != 0) begin
          dec_phase = TK_START;
          run_backref(dec_code[15:12] + 2);
        end else begin
          dec_phase = TK_LONG;
        end
      end
      default: begin
        dec_phase = TK_START;
        run_backref(b + 18);
      end
    endcase
    if (!dec_done && (last || dec_count >= dec_cap)) end_stream(yaz0_pkg::StOk);
    pack_run();
  endfunction

  // Offer one compressed byte, predict its output, then wait until it is taken
  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    decode_byte(b, last);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off until every expected word is out and the core is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    drain();
    cap_we    <= 1'b1;
    cap_wdata <= v;
    dec_cap = v;
    @(posedge clk);
    cap_we    <= 1'b0;
    cap_wdata <= $urandom;
  endtask

  task automatic send_backref(int unsigned span, int unsigned len);
    logic [11:0] d;
    d = 12'(span - 1);
    if (len <= 17) begin
      send_byte({4'(len - 2), d[11:8]}, 1'b0);
      send_byte(d[7:0], 1'b0);
    end else begin
      send_byte({4'h0, d[11:8]}, 1'b0);
      send_byte(d[7:0], 1'b0);
      send_byte(8'(len - 18), 1'b0);
    end
  endtask

  // One flag byte with eight random tokens; references stay inside the output
  task automatic send_token_group();
    logic [7:0] flags;
    int unsigned maxd;
    int unsigned len;
    flags = 8'($urandom);
    if (dec_count == 0) flags[7] = 1'b1;
    send_byte(flags, 1'b0);
    for (int i = 7; i >= 0; i--) begin
      if (flags[i]) begin
        send_byte(8'($urandom), 1'b0);
      end else begin
        maxd = (dec_count > yaz0_pkg::WindowBytes) ? yaz0_pkg::WindowBytes : dec_count;
        len = ($urandom_range(99) < 80) ? $urandom_range(17, 3) : $urandom_range(273, 18);
        send_backref($urandom_range(maxd, 1), len);
      end
    end
  endtask

  task automatic test_header();
    write_capacity(32'hffff_ffff);
    send_byte(yaz0_pkg::MagicY, 1'b0);
    send_byte(yaz0_pkg::MagicA, 1'b0);
    send_byte(yaz0_pkg::MagicZ, 1'b0);
    send_byte(yaz0_pkg::Magic0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (8) send_byte(8'($urandom), 1'b0);
  endtask

  // Byte extremes, overlapping copy, both length forms at their limits
  task automatic test_directed_tokens();
    send_byte(8'b1100_0000, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_backref(1, 3);
    send_backref(2, 17);
    send_backref(1, 18);
    send_backref(20, 273);
    send_backref(3, 4);
    send_backref(7, 9);
  endtask

  task automatic test_random_tokens();
    send_idle_pct = 8;
    recv_idle_pct = 58;
    repeat (2) send_token_group();
    write_capacity(32'h8000_0000);
    send_idle_pct = 58;
    recv_idle_pct = 8;
    repeat (2) send_token_group();
    write_capacity(32'hffff_fffe);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) send_token_group();
  endtask

  // Lower the capacity just past the count so a long copy gets clipped
  task automatic test_capacity_clip();
    write_capacity(dec_count + 5);
    send_byte(8'h00, 1'b0);
    send_backref(1, 200);
  endtask

  task automatic test_after_end();
    write_capacity(32'h0000_0000);
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // Drive receiver backpressure
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    dec_word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word bytes=%h count=%0d", out_ch.out_bytes, out_ch.out_count);
        fails++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.out_bytes !== e.bytes) begin
          $error("out_bytes exp %h got %h", e.bytes, out_ch.out_bytes);
          fails++;
        end
        if (out_ch.out_count !== e.cnt) begin
          $error("out_count exp %0d got %0d", e.cnt, out_ch.out_count);
          fails++;
        end
        if (out_ch.run_end !== e.run_end) begin
          $error("run_end exp %0d got %0d", e.run_end, out_ch.run_end);
          fails++;
        end
        if (out_ch.stream_end !== e.stream_end) begin
          $error("stream_end exp %0d got %0d", e.stream_end, out_ch.stream_end);
          fails++;
        end
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status);
          fails++;
        end
      end
    end
  end

  // Stop on a long stretch with no word moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cap_we = 1'b0;
    cap_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    dec_cap = 32'hffff_ffff;
    dec_hdr_idx = 0;
    dec_size = '0;
    dec_count = '0;
    dec_flags = '0;
    dec_flags_left = 0;
    dec_phase = TK_START;
    dec_code = '0;
    dec_err = yaz0_pkg::StOk;
    dec_magic_bad = 1'b0;
    dec_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header();
    test_directed_tokens();
    test_random_tokens();
    test_capacity_clip();
    test_after_end();
    drain();

    if (fails == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
